>>> rtl/pfa_pkg.sv
// Package for the partition fit allocator: sizes, field widths, fit codes
// and the structs passed between the register block, core and compare unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

	localparam int NUM_PARTITIONS = 16;
	localparam int SIZE_BITS      = 20;

	// fixed field widths of the stream items and registers
	localparam int SLOT_W  = 4;
	localparam int MODE_W  = 2;
	localparam int COUNT_W = 5;
	localparam int TDATA_W = 32;
	localparam int ITEM_W  = 1 + SLOT_W + SIZE_BITS;

	// table index and scan counter widths
	localparam int TIDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam int CNT_W  = $clog2(NUM_PARTITIONS + 1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// APB register indexes (byte address / 4)
	localparam logic REG_FIT_MODE   = 1'b0;
	localparam logic REG_PART_COUNT = 1'b1;
	localparam int   PADDR_W        = 3;

	typedef struct packed {
		logic [MODE_W-1:0]  fit_mode;
		logic [COUNT_W-1:0] partition_count;
	} cfg_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] cap;
		logic [SIZE_BITS-1:0] req;
		logic [SIZE_BITS-1:0] best_cap;
		logic [MODE_W-1:0]    mode;
		logic                 found;
	} alu_in_t;

	typedef struct packed {
		logic                 take;
		logic [SIZE_BITS-1:0] diff;
	} alu_out_t;

	typedef struct packed {
		logic                 granted;
		logic [SLOT_W-1:0]    chosen_slot;
		logic [SIZE_BITS-1:0] left_over;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/partition_fit_allocator_top.sv
// channel  | dir | beat fields (tdata, lsb first)
// s_axis   | in  | opcode[0], slot_index[4:1], amount[24:5], zero pad
// m_axis   | out | granted[0], chosen_slot[4:1], left_over[24:5], zero pad
// apb      | in  | 0x0 fit_mode, 0x4 partition_count
//
// A load passes through the done state to the output register; a request scans
// min(partition_count, 16) table entries, one table entry per cycle through the
// single compare unit, and if granted then writes the entry back in the write
// state. Reset clears the table and registers at once. One item is in
// work at a time; the next input beat is taken while the last result still waits.
// Depends on pfa_pkg, pfa_regs, pfa_core.
`timescale 1ns / 1ps
`default_nettype none
module partition_fit_allocator_top
	import pfa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // opcode, slot_index, amount
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata,  // granted, chosen_slot, left_over
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	cfg_t             cfg;
	result_t          res;
	logic             res_valid;
	logic             res_ready;
	logic             m_tvalid_q;
	logic [ITEM_W-1:0] m_item_q;

	pfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfa_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tdata[0]),
		.in_slot   (s_tdata[SLOT_W:1]),
		.in_amount (s_tdata[ITEM_W-1:SLOT_W+1]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output beat register: load when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_item_q <= {res.left_over, res.chosen_slot, res.granted};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_item_q);

endmodule
`default_nettype wire

>>> rtl/pfa_alu.sv
// Shared compare and subtract unit of the partition fit allocator.
// Depends on pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfa_alu
	import pfa_pkg::*;
(
	input  alu_in_t  ain,
	output alu_out_t aout
);

	logic fits;
	logic better;

	always_comb begin
		fits = !(ain.req > ain.cap);
		case (ain.mode)
			MODE_BEST:  better = ain.cap < ain.best_cap;
			MODE_WORST: better = ain.cap > ain.best_cap;
			default:    better = 1'b0;
		endcase
		// the first candidate that fits is always taken; a later one replaces it only when strictly better
		aout.take = fits && (!ain.found || better);
		aout.diff = ain.cap - ain.req;
	end

endmodule
`default_nettype wire

>>> rtl/pfa_regs.sv
// APB configuration registers of the partition fit allocator.
// Depends on pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfa_regs
	import pfa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [MODE_W-1:0]  fit_mode_q;
	logic [COUNT_W-1:0] part_count_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= '0;
			part_count_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_FIT_MODE:   fit_mode_q   <= pwdata[MODE_W-1:0];
				REG_PART_COUNT: part_count_q <= pwdata[COUNT_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FIT_MODE:   prdata = 32'(fit_mode_q);
			REG_PART_COUNT: prdata = 32'(part_count_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.fit_mode        = fit_mode_q;
	assign cfg.partition_count = part_count_q;

endmodule
`default_nettype wire

>>> rtl/pfa_core.sv
// Sequencer and capacity table of the partition fit allocator: one table
// entry per cycle goes through the shared compare unit, then write-back if one fits.
// Depends on pfa_pkg and pfa_alu.
`timescale 1ns / 1ps
`default_nettype none
module pfa_core
	import pfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  cfg_t                      cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_opcode,
	input  wire logic [SLOT_W-1:0]    in_slot,
	input  wire logic [SIZE_BITS-1:0] in_amount,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output result_t                   res
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [SIZE_BITS-1:0] cap_q [NUM_PARTITIONS];
	logic [SIZE_BITS-1:0] amt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     used_q;
	logic [TIDX_W-1:0]    pick_q;
	logic [SIZE_BITS-1:0] pick_cap_q;
	logic                 found_q;
	logic [MODE_W-1:0]    mode_q;
	result_t              res_q;

	logic                 accept;
	logic                 load_ok;
	alu_in_t              ain;
	alu_out_t             aout;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_ok   = int'(in_slot) < NUM_PARTITIONS;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_comb begin
		ain.cap      = (state_q == ST_WRITE) ? pick_cap_q : cap_q[idx_q[TIDX_W-1:0]];
		ain.req      = amt_q;
		ain.best_cap = pick_cap_q;
		ain.mode     = mode_q;
		ain.found    = found_q;
	end

	pfa_alu u_alu (
		.ain  (ain),
		.aout (aout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_PARTITIONS; i++) begin
				cap_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_opcode == OP_LOAD) begin
						if (load_ok) begin
							cap_q[TIDX_W'(in_slot)] <= in_amount;
						end
						state_q <= ST_DONE;
					end else if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == used_q) begin
						state_q <= found_q ? ST_WRITE : ST_DONE;
					end
				end
				ST_WRITE: begin
					cap_q[pick_q] <= aout.diff;
					state_q       <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				amt_q   <= in_amount;
				mode_q  <= cfg.fit_mode;
				idx_q   <= '0;
				found_q <= 1'b0;
				pick_q  <= '0;
				used_q  <= (int'(cfg.partition_count) > NUM_PARTITIONS) ?
				           CNT_W'(NUM_PARTITIONS) : CNT_W'(cfg.partition_count);
				res_q.granted     <= 1'b0;
				res_q.chosen_slot <= in_slot;
				res_q.left_over   <= load_ok ? in_amount : '0;
			end
			ST_SCAN: begin
				if (idx_q != used_q) begin
					if (aout.take) begin
						found_q    <= 1'b1;
						pick_q     <= idx_q[TIDX_W-1:0];
						pick_cap_q <= ain.cap;
					end
					idx_q <= idx_q + 1'b1;
				end else if (!found_q) begin
					// refused: report zero slot and zero capacity
					res_q.chosen_slot <= '0;
					res_q.left_over   <= '0;
				end
			end
			ST_WRITE: begin
				res_q.granted     <= 1'b1;
				res_q.chosen_slot <= SLOT_W'(pick_q);
				res_q.left_over   <= aout.diff;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/pfa_checker.sv
// Port-level checks for the partition fit allocator top level, with the
// bind that attaches them. Depends on pfa_pkg and partition_fit_allocator_top.
`timescale 1ns / 1ps
`default_nettype none
module pfa_checker
	import pfa_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic               pready
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// no result can appear in the cycle straight after an input beat
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:ITEM_W] == '0)
		else $error("padding bits of result beat not zero");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind partition_fit_allocator_top pfa_checker u_pfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for partition_fit_allocator_top: directed table, then random phases.
// Predicts placements from its own capacity table and checks result beats field by field.
// Depends on pfa_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb;
	import pfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_DIRECTED     = 32;
	localparam int N_PHASES       = 15;
	localparam int PHASE_ITEMS    = 110;
	localparam int TAIL_CYCLES    = 40;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;
	localparam result_t NO_RESULT = '0;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// opcode ends up in bit 0 when cast onto tdata
	typedef struct packed {
		logic [SIZE_BITS-1:0] amount;
		logic [SLOT_W-1:0]    slot;
		logic                 opcode;
	} alloc_item_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 opcode;
		logic [SLOT_W-1:0]    slot;
		logic [SIZE_BITS-1:0] amount;
		logic                 reg_sel;
		logic [COUNT_W-1:0]   reg_val;
		logic                 typed;
		result_t              want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;  // opcode, slot_index, amount, zero pad
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;       // granted, chosen_slot, left_over, zero pad
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	logic [SIZE_BITS-1:0] cap_left [NUM_PARTITIONS];
	logic [MODE_W-1:0]    fit_rule = MODE_FIRST;
	logic [COUNT_W-1:0]   parts_used = '0;
	result_t              pending_results [$];
	int                   mismatches = 0;
	int                   idle_cycles = 0;
	int                   stall_left = 0;
	logic                 steady = 1'b0;

	row_t directed_rows [N_DIRECTED] = '{
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd0, 1'b0, 5'd0, TYPED, '{1'b0, 4'd0, 20'd0}},
		'{ROW_ITEM, OP_LOAD, 4'd0, 20'hFFFFF, 1'b0, 5'd0, TYPED, '{1'b0, 4'd0, 20'hFFFFF}},
		'{ROW_ITEM, OP_LOAD, 4'd15, 20'd0, 1'b0, 5'd0, TYPED, '{1'b0, 4'd15, 20'd0}},
		'{ROW_ITEM, OP_LOAD, 4'd1, 20'd100, 1'b0, 5'd0, TYPED, '{1'b0, 4'd1, 20'd100}},
		'{ROW_ITEM, OP_LOAD, 4'd2, 20'd50, 1'b0, 5'd0, TYPED, '{1'b0, 4'd2, 20'd50}},
		'{ROW_ITEM, OP_LOAD, 4'd3, 20'd300, 1'b0, 5'd0, TYPED, '{1'b0, 4'd3, 20'd300}},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_PART_COUNT, 5'd4, PREDICTED, NO_RESULT},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_FIT_MODE, 5'(MODE_FIRST), PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd9, 20'd40, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd15, 20'hFFFFF, 1'b0, 5'd0, TYPED, '{1'b0, 4'd0, 20'd0}},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_FIT_MODE, 5'(MODE_BEST), PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd50, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd0, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_FIT_MODE, 5'(MODE_WORST), PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd10, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_FIT_MODE, 5'(MODE_SPARE), PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd60, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_LOAD, 4'd15, 20'h80000, 1'b0, 5'd0, TYPED, '{1'b0, 4'd15, 20'h80000}},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_PART_COUNT, 5'd31, PREDICTED, NO_RESULT},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_FIT_MODE, 5'(MODE_BEST), PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'h7FFFF, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd0, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_PART_COUNT, 5'd16, PREDICTED, NO_RESULT},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_FIT_MODE, 5'(MODE_WORST), PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_LOAD, 4'd5, 20'hAAAAA, 1'b0, 5'd0, TYPED, '{1'b0, 4'd5, 20'hAAAAA}},
		'{ROW_ITEM, OP_LOAD, 4'd10, 20'h55555, 1'b0, 5'd0, TYPED, '{1'b0, 4'd10, 20'h55555}},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd1, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_LOAD, 4'd7, 20'hFFFFF, 1'b0, 5'd0, TYPED, '{1'b0, 4'd7, 20'hFFFFF}},
		'{ROW_ITEM, OP_LOAD, 4'd8, 20'hFFFFF, 1'b0, 5'd0, TYPED, '{1'b0, 4'd8, 20'hFFFFF}},
		'{ROW_ITEM, OP_ALLOC, 4'd0, 20'd0, 1'b0, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_REG, OP_LOAD, 4'd0, 20'd0, REG_PART_COUNT, 5'd0, PREDICTED, NO_RESULT},
		'{ROW_ITEM, OP_ALLOC, 4'd3, 20'd0, 1'b0, 5'd0, TYPED, '{1'b0, 4'd0, 20'd0}}
	};

	partition_fit_allocator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// Apply one item to the shadow table and return the result beat it should produce.
	function automatic result_t compute_placement(alloc_item_t it);
		result_t              r;
		int                   used;
		logic                 found;
		logic                 take;
		int                   pick;
		logic [SIZE_BITS-1:0] pick_cap;
		r = '0;
		found = 1'b0;
		pick = 0;
		pick_cap = '0;
		if (it.opcode == OP_LOAD) begin
			r.chosen_slot = it.slot;
			if (it.slot < NUM_PARTITIONS) begin
				cap_left[it.slot] = it.amount;
				r.left_over = it.amount;
			end
			return r;
		end
		used = (parts_used > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(parts_used);
		for (int j = 0; j < used; j++) begin
			if (it.amount > cap_left[j])
				continue;
			if (!found)
				take = 1'b1;
			else begin
				case (fit_rule)
					MODE_BEST:  take = cap_left[j] < pick_cap;
					MODE_WORST: take = cap_left[j] > pick_cap;
					default:    take = 1'b0;
				endcase
			end
			if (take) begin
				found = 1'b1;
				pick = j;
				pick_cap = cap_left[j];
			end
		end
		if (found) begin
			cap_left[pick] = pick_cap - it.amount;
			r.granted = 1'b1;
			r.chosen_slot = SLOT_W'(pick);
			r.left_over = cap_left[pick];
		end
		return r;
	endfunction

	// Mostly no gap, some short ones, a few long stretches.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(alloc_item_t it, logic typed, result_t want);
		result_t guess;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(it);
		do @(posedge clk); while (!s_tready);
		guess = compute_placement(it);
		pending_results.push_back(typed ? want : guess);
	endtask

	task automatic idle_gap(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Drop valid and hold until every outstanding result beat has come back.
	task automatic wait_drained();
		idle_gap(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_reg(logic sel, logic [COUNT_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_FIT_MODE)
			fit_rule = val[MODE_W-1:0];
		else
			parts_used = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(val)) begin
			$display("%0t: register %0d readback expected %0d actual %0d",
				$time, sel, val, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready   <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.granted) begin
					$display("%0t: granted expected %0d actual %0d",
						$time, want.granted, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[4:1] !== want.chosen_slot) begin
					$display("%0t: chosen_slot expected %0d actual %0d",
						$time, want.chosen_slot, m_tdata[4:1]);
					mismatches++;
				end
				if (m_tdata[24:5] !== want.left_over) begin
					$display("%0t: left_over expected %0d actual %0d",
						$time, want.left_over, m_tdata[24:5]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		alloc_item_t          it;
		row_t                 row;
		logic [SIZE_BITS-1:0] probe;
		logic [COUNT_W-1:0]   count_pick;
		for (int j = 0; j < NUM_PARTITIONS; j++)
			cap_left[j] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.kind == ROW_REG) begin
				wait_drained();
				program_reg(row.reg_sel, row.reg_val);
			end else begin
				it.opcode = row.opcode;
				it.slot   = row.slot;
				it.amount = row.amount;
				send_beat(it, row.typed, row.want);
				idle_gap(pick_gap());
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			steady = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0:       count_pick = '0;
				1:       count_pick = COUNT_W'($urandom_range(17, 31));
				2, 3:    count_pick = 5'd16;
				default: count_pick = COUNT_W'($urandom_range(1, 16));
			endcase
			program_reg(REG_PART_COUNT, count_pick);
			program_reg(REG_FIT_MODE, COUNT_W'($urandom_range(0, 3)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.slot = SLOT_W'($urandom_range(0, 15));
				if ($urandom_range(0, 99) < 35) begin
					it.opcode = OP_LOAD;
					case ($urandom_range(0, 7))
						0:       it.amount = '0;
						1:       it.amount = '1;
						2, 3:    it.amount = SIZE_BITS'($urandom);
						4, 5:    it.amount = SIZE_BITS'($urandom_range(0, 65535));
						default: it.amount = SIZE_BITS'($urandom_range(0, 4095));
					endcase
				end else begin
					it.opcode = OP_ALLOC;
					probe = cap_left[$urandom_range(0, NUM_PARTITIONS - 1)];
					case ($urandom_range(0, 9))
						0:          it.amount = '0;
						1:          it.amount = '1;
						2:          it.amount = SIZE_BITS'($urandom);
						3, 4, 5, 6: it.amount = SIZE_BITS'($urandom_range(0, probe));
						default:    it.amount = SIZE_BITS'($urandom_range(1, 4096));
					endcase
				end
				send_beat(it, PREDICTED, NO_RESULT);
				idle_gap(pick_gap());
				if (ph == 3 && n == PHASE_ITEMS / 2)
					wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> partition_fit_allocator_top.f
rtl/pfa_pkg.sv
rtl/pfa_alu.sv
rtl/pfa_regs.sv
rtl/pfa_core.sv
rtl/partition_fit_allocator_top.sv
rtl/pfa_checker.sv
tb/tb.sv
